[rtl/core/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SDTA_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SDTA_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/sdta_pkg.sv]
package sdta_pkg;

	localparam int SLOTS      = 16;
	localparam int IDX_W      = $clog2(SLOTS);
	localparam int CNT_W      = $clog2(SLOTS + 1);
	localparam int TAG_BITS   = 64;
	localparam int TIME_W     = 32;
	localparam int MS_W       = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [1:0] {
		OP_BEGIN = 2'd0,
		OP_END   = 2'd1,
		OP_REPLY = 2'd2,
		OP_TICK  = 2'd3
	} op_e;

	typedef enum logic [1:0] {
		ST_NONE  = 2'd0,
		ST_EXIST = 2'd1,
		ST_NEW   = 2'd2,
		ST_FULL  = 2'd3
	} store_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_SESSIONS = 2'd0,
		CFG_EXPIRY       = 2'd1,
		CFG_INTERVAL     = 2'd2
	} cfg_e;

	// Item context seen by every cell while a beat is in work.
	typedef struct packed {
		logic                active;
		op_e                 op;
		logic [TIME_W-1:0]   now;
		logic [TAG_BITS-1:0] host;
		logic [TAG_BITS-1:0] sid;
		logic [CNT_W-1:0]    n_use;
		logic [MS_W-1:0]     expiry;
	} ctx_t;

	// Token handed from cell to cell.
	typedef struct packed {
		logic                found;
		logic [IDX_W-1:0]    match_idx;
		logic [TAG_BITS-1:0] match_dig;
		logic                have_free;
		logic [IDX_W-1:0]    free_idx;
		logic                add;
		logic [CNT_W-1:0]    count;
	} probe_t;

	// Slot write / table clear, broadcast for one cycle.
	typedef struct packed {
		logic                clr_all;
		logic                en;
		logic [IDX_W-1:0]    idx;
		logic                fresh;
		logic                tags;
		logic [TAG_BITS-1:0] host;
		logic [TAG_BITS-1:0] sid;
		logic [TAG_BITS-1:0] dig;
		logic [TIME_W-1:0]   now;
	} wr_cmd_t;

endpackage

[rtl/core/sdta_if.sv]
interface sdta_req_if import sdta_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [1:0]          op;
	logic [TIME_W-1:0]   now_ms;
	logic                link_up;
	logic [TAG_BITS-1:0] new_nonce;
	logic [TAG_BITS-1:0] host_tag;
	logic [TAG_BITS-1:0] session_id;
	logic [TAG_BITS-1:0] status_digest;

	modport source (output valid, op, now_ms, link_up, new_nonce, host_tag,
		session_id, status_digest, input ready);
	modport sink (input valid, op, now_ms, link_up, new_nonce, host_tag,
		session_id, status_digest, output ready);
endinterface

interface sdta_rsp_if import sdta_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                active;
	logic [1:0]          store_status;
	logic [IDX_W-1:0]    slot;
	logic                status_changed;
	logic                add_entry;
	logic                send_search;
	logic [CNT_W-1:0]    expired_count;
	logic                table_updated;
	logic [TAG_BITS-1:0] cur_nonce;

	modport source (output valid, active, store_status, slot, status_changed, add_entry,
		send_search, expired_count, table_updated, cur_nonce, input ready);
	modport sink (input valid, active, store_status, slot, status_changed, add_entry,
		send_search, expired_count, table_updated, cur_nonce, output ready);
endinterface

[rtl/core/sdta_cell.sv]
module sdta_cell import sdta_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] idx,
	input  ctx_t             ctx,
	input  wr_cmd_t          wr,
	input  logic             prb_in_vld,
	input  probe_t           prb_in,
	output logic             prb_out_vld,
	output probe_t           prb_out
);

	logic                valid_q;
	logic [TAG_BITS-1:0] host_q;
	logic [TAG_BITS-1:0] id_q;
	logic [TAG_BITS-1:0] dig_q;
	logic [TIME_W-1:0]   time_q;
	logic                prb_vld_q;
	probe_t              prb_q;

	logic   in_use;
	logic   expire;
	logic   wr_hit;
	probe_t prb_nx;

	assign in_use = {1'b0, idx} < ctx.n_use;
	assign wr_hit = wr.en && (wr.idx == idx);
	assign expire = (ctx.op == OP_TICK) && ctx.active && valid_q && in_use
		&& ((ctx.now - time_q) > TIME_W'(ctx.expiry));

	always_comb begin
		prb_nx = prb_in;
		if (ctx.op == OP_REPLY) begin
			// first matching host wins; lowest free slot ahead of it is the fallback
			if (!prb_in.found) begin
				if (valid_q && in_use && (host_q == ctx.host)) begin
					prb_nx.found     = 1'b1;
					prb_nx.match_idx = idx;
					prb_nx.match_dig = dig_q;
				end else if (!valid_q && in_use && !prb_in.have_free) begin
					prb_nx.have_free = 1'b1;
					prb_nx.free_idx  = idx;
				end
			end
			if (valid_q && in_use && (id_q == ctx.sid)) begin
				prb_nx.add = 1'b1;
			end
		end
		if (expire) begin
			prb_nx.count = prb_in.count + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			prb_vld_q <= 1'b0;
		end else begin
			prb_vld_q <= prb_in_vld;
			if (wr.clr_all) begin
				valid_q <= 1'b0;
			end else if (wr_hit) begin
				valid_q <= 1'b1;
			end else if (prb_in_vld && expire) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (prb_in_vld) begin
			prb_q <= prb_nx;
		end
		if (wr_hit) begin
			time_q <= wr.now;
			if (wr.fresh) begin
				// fresh slot starts cleared; tags land only with a new digest
				dig_q  <= wr.dig;
				host_q <= wr.tags ? wr.host : '0;
				id_q   <= wr.tags ? wr.sid : '0;
			end else if (wr.tags) begin
				dig_q  <= wr.dig;
				host_q <= wr.host;
				id_q   <= wr.sid;
			end
		end
	end

	assign prb_out_vld = prb_vld_q;
	assign prb_out     = prb_q;

endmodule

[rtl/core/session_discovery_table_with_aging_unit.sv]
// Channel  | Dir | Beat content
// ---------+-----+---------------------------------------------------------------
// req      | in  | op, now_ms, link_up, new_nonce, host_tag, session_id,
//          |     | status_digest
// rsp      | out | active, store_status, slot, status_changed, add_entry,
//          |     | send_search, expired_count, table_updated, cur_nonce
// cfg      | in  | cfg_we / cfg_idx / cfg_data, plain register writes
//
// Reply and tick beats: after accept, start_q launches the token, which walks the
// 16-cell slot chain one cell per cycle; the FINISH state then registers the result.
// Begin and end beats go from accept straight to FINISH; the next beat is taken once
// FINISH returns to IDLE. One beat in work at a time; the result sits in an output
// register, so req is taken again while rsp waits. A stalled rsp holds the finish step.
// arst_n clears control state and slot valid bits; slot payload is not reset.
module session_discovery_table_with_aging_unit import sdta_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	sdta_req_if.sink              req,
	sdta_rsp_if.source            rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SWEEP  = 3'b010,
		S_FINISH = 3'b100
	} state_e;

	state_e state_q;

	// configuration
	logic [CNT_W-1:0] max_sess_q;
	logic [MS_W-1:0]  expiry_q;
	logic [MS_W-1:0]  interval_q;

	// block state
	logic                search_on_q;
	logic [TAG_BITS-1:0] nonce_q;
	logic [TIME_W-1:0]   last_sent_q;
	logic                updated_q;

	// accepted beat
	op_e                 op_q;
	logic [TIME_W-1:0]   now_q;
	logic                link_q;
	logic [TAG_BITS-1:0] new_nonce_q;
	logic [TAG_BITS-1:0] host_q;
	logic [TAG_BITS-1:0] sid_q;
	logic [TAG_BITS-1:0] dig_q;
	logic                start_q;

	// output register
	logic                rsp_vld_q;
	logic                active_q;
	store_e              status_q;
	logic [IDX_W-1:0]    slot_q;
	logic                changed_q;
	logic                add_q;
	logic                send_q;
	logic [CNT_W-1:0]    expired_q;
	logic                upd_out_q;
	logic [TAG_BITS-1:0] nonce_out_q;

	logic   accept;
	logic   out_free;
	logic   fire;
	ctx_t   ctx;
	wr_cmd_t wr_nx;
	wr_cmd_t wr_cmd;

	logic   prb_vld [SLOTS+1];
	probe_t prb     [SLOTS+1];
	probe_t last;

	logic                act_nx;
	logic                upd_nx;
	logic [TAG_BITS-1:0] nonce_nx;
	logic [TIME_W-1:0]   sent_nx;
	store_e              status_nx;
	logic [IDX_W-1:0]    slot_nx;
	logic                changed_nx;
	logic                add_nx;
	logic                send_nx;
	logic [CNT_W-1:0]    expired_nx;
	logic                stored;
	logic [IDX_W-1:0]    target;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign out_free = !rsp_vld_q || rsp.ready;
	assign fire     = (state_q == S_FINISH) && out_free;

	// slots above the table size saturate
	assign ctx.active = search_on_q;
	assign ctx.op     = op_q;
	assign ctx.now    = now_q;
	assign ctx.host   = host_q;
	assign ctx.sid    = sid_q;
	assign ctx.n_use  = (max_sess_q > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : max_sess_q;
	assign ctx.expiry = expiry_q;

	// slot chain: token enters cell 0 in the cycle after accept
	assign prb_vld[0] = start_q;
	assign prb[0]     = '0;

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		sdta_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.idx         (IDX_W'(g)),
			.ctx         (ctx),
			.wr          (wr_cmd),
			.prb_in_vld  (prb_vld[g]),
			.prb_in      (prb[g]),
			.prb_out_vld (prb_vld[g+1]),
			.prb_out     (prb[g+1])
		);
	end

	// last cell's token holds until the next sweep
	assign last = prb[SLOTS];

	always_comb begin
		act_nx     = search_on_q;
		upd_nx     = updated_q;
		nonce_nx   = nonce_q;
		sent_nx    = last_sent_q;
		status_nx  = ST_NONE;
		slot_nx    = '0;
		changed_nx = 1'b0;
		add_nx     = 1'b0;
		send_nx    = 1'b0;
		expired_nx = '0;
		stored     = 1'b0;
		target     = last.found ? last.match_idx : last.free_idx;
		wr_nx      = '0;
		wr_nx.idx  = target;
		wr_nx.host = host_q;
		wr_nx.sid  = sid_q;
		wr_nx.dig  = dig_q;
		wr_nx.now  = now_q;
		unique case (op_q)
			OP_BEGIN: begin
				if (!search_on_q && link_q) begin
					act_nx        = 1'b1;
					upd_nx        = 1'b0;
					sent_nx       = '0;
					nonce_nx      = new_nonce_q;
					wr_nx.clr_all = 1'b1;
				end
			end
			OP_END: begin
				act_nx = 1'b0;
			end
			OP_REPLY: begin
				stored = search_on_q && (last.found || last.have_free);
				if (search_on_q) begin
					if (last.found) begin
						status_nx = ST_EXIST;
					end else if (last.have_free) begin
						status_nx = ST_NEW;
					end else begin
						status_nx = ST_FULL;
					end
				end
				if (stored) begin
					// a fresh slot compares against a cleared digest
					changed_nx  = last.found ? (last.match_dig != dig_q) : (dig_q != '0);
					slot_nx     = target;
					wr_nx.en    = 1'b1;
					wr_nx.fresh = !last.found;
					wr_nx.tags  = changed_nx;
				end
				// written slot counts with its post-write id
				add_nx = last.add
					|| (stored && (changed_nx || (!last.found && (sid_q == '0))));
				if (changed_nx) begin
					upd_nx = 1'b1;
				end
			end
			OP_TICK: begin
				send_nx = search_on_q && ((now_q - last_sent_q) > TIME_W'(interval_q));
				if (send_nx) begin
					sent_nx = now_q;
				end
				expired_nx = last.count;
				if (last.count != '0) begin
					upd_nx = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		wr_cmd         = wr_nx;
		wr_cmd.en      = fire && wr_nx.en;
		wr_cmd.clr_all = fire && wr_nx.clr_all;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= 1'b0;
			rsp_vld_q   <= 1'b0;
			max_sess_q  <= CNT_W'(SLOTS);
			expiry_q    <= MS_W'(4000);
			interval_q  <= MS_W'(1000);
			search_on_q <= 1'b0;
			nonce_q     <= '0;
			last_sent_q <= '0;
			updated_q   <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_MAX_SESSIONS: max_sess_q <= cfg_data[CNT_W-1:0];
					CFG_EXPIRY:       expiry_q   <= cfg_data[MS_W-1:0];
					CFG_INTERVAL:     interval_q <= cfg_data[MS_W-1:0];
					default: begin
					end
				endcase
			end
			// a new result replaces the one being taken in the same cycle
			if (fire) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if ((op_e'(req.op) == OP_REPLY) || (op_e'(req.op) == OP_TICK)) begin
							start_q <= 1'b1;
							state_q <= S_SWEEP;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_SWEEP: begin
					if (prb_vld[SLOTS]) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						search_on_q <= act_nx;
						updated_q   <= upd_nx;
						nonce_q     <= nonce_nx;
						last_sent_q <= sent_nx;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= op_e'(req.op);
			now_q       <= req.now_ms;
			link_q      <= req.link_up;
			new_nonce_q <= req.new_nonce;
			host_q      <= req.host_tag;
			sid_q       <= req.session_id;
			dig_q       <= req.status_digest;
		end
		if (fire) begin
			active_q    <= act_nx;
			status_q    <= status_nx;
			slot_q      <= slot_nx;
			changed_q   <= changed_nx;
			add_q       <= add_nx;
			send_q      <= send_nx;
			expired_q   <= expired_nx;
			upd_out_q   <= upd_nx;
			nonce_out_q <= nonce_nx;
		end
	end

	assign rsp.valid            = rsp_vld_q;
	assign rsp.active           = active_q;
	assign rsp.store_status     = status_q;
	assign rsp.slot             = slot_q;
	assign rsp.status_changed   = changed_q;
	assign rsp.add_entry        = add_q;
	assign rsp.send_search      = send_q;
	assign rsp.expired_count    = expired_q;
	assign rsp.table_updated    = upd_out_q;
	assign rsp.cur_nonce        = nonce_out_q;

endmodule

[rtl/core/sdta_checker.sv]
`include "assert_macros.svh"

module sdta_checker import sdta_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic                active,
	input logic [1:0]          store_status,
	input logic                status_changed,
	input logic [CNT_W-1:0]    expired_count,
	input logic                table_updated,
	input logic [TAG_BITS-1:0] cur_nonce
);

	logic any_store;
	logic written;
	logic exp_ok;

	assign any_store = (store_status != ST_NONE);
	assign written   = (store_status == ST_EXIST) || (store_status == ST_NEW);
	assign exp_ok    = (expired_count <= CNT_W'(SLOTS));

	// one beat in work at a time
	`SDTA_ASSERT_NXT(a_one_in_work, clk, arst_n, req_valid && req_ready, !req_ready, "req taken while busy")

	`SDTA_ASSERT_IMP(a_store_act, clk, arst_n, rsp_valid && any_store, active, "store with search off")

	`SDTA_ASSERT_IMP(a_chg_stored, clk, arst_n, rsp_valid && status_changed, table_updated && written, "change without store")

	`SDTA_ASSERT_IMP(a_exp_flag, clk, arst_n, rsp_valid && (expired_count != '0), table_updated && exp_ok, "expiry not flagged")

	`SDTA_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(cur_nonce), "result dropped")

endmodule

bind session_discovery_table_with_aging_unit sdta_checker u_sdta_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.active           (rsp.active),
	.store_status     (rsp.store_status),
	.status_changed   (rsp.status_changed),
	.expired_count    (rsp.expired_count),
	.table_updated    (rsp.table_updated),
	.cur_nonce        (rsp.cur_nonce)
);
